// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define PTSS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/ptss_pkg.sv =====
`default_nettype none

package ptss_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int SLOT_W          = 4;
    localparam logic [7:0] TICK_DIVIDE_RST = 8'd10;

    typedef enum logic [2:0] {
        ACT_ADD      = 3'd0,
        ACT_DELETE   = 3'd1,
        ACT_STATUS   = 3'd2,
        ACT_TICK     = 3'd3,
        ACT_DISPATCH = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        KIND_ADDED      = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_DELETED    = 3'd2,
        KIND_NOT_FOUND  = 3'd3,
        KIND_STATUS     = 3'd4,
        KIND_RUN        = 3'd5,
        KIND_NONE_READY = 3'd6,
        KIND_TICK_DONE  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_RUNNABLE = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_STOPPED  = 2'd2,
        ST_ERROR    = 2'd3
    } slot_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  task_id;
        logic [15:0] period;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        run_id;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        task_status;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] period;
        logic [15:0] countdown;
        slot_state_t state;
    } entry_t;

    localparam entry_t ENTRY_RST = '{
        ident:     8'd0,
        period:    16'd0,
        countdown: 16'd0,
        state:     ST_STOPPED
    };

endpackage

`default_nettype wire

// ===== sv/ptss_table.sv =====
`default_nettype none

// Slot table: one write port, one registered read port.
// Entries never written since reset read back as the reset entry.
module ptss_table #(
    parameter int NUM_SLOTS = ptss_pkg::NUM_SLOTS_DEF,
    parameter int AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output ptss_pkg::entry_t       rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire ptss_pkg::entry_t  wr_data
);
    import ptss_pkg::*;

    entry_t               mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] written_reg;
    entry_t               rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : ENTRY_RST;

endmodule

`default_nettype wire

// ===== sv/ptss_seq.sv =====
`default_nettype none

// Command sequencer: walks the slot table one entry per cycle (held while a run
// result waits), one read in flight, and writes back each entry it modifies.
module ptss_seq #(
    parameter int NUM_SLOTS = ptss_pkg::NUM_SLOTS_DEF,
    parameter int AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire ptss_pkg::in_item_t item,
    input  wire logic [7:0]        tick_divide,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    input  wire ptss_pkg::entry_t  rd_data,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output ptss_pkg::entry_t       wr_data,
    output logic                   res_valid,
    output ptss_pkg::out_item_t    res,
    input  wire logic              res_ready
);
    import ptss_pkg::*;

    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    in_item_t    cmd_reg, cmd_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic        ev_valid_reg, ev_valid_next;
    logic [AW-1:0] ev_idx_reg, ev_idx_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    out_item_t   pend_reg, pend_next;
    out_item_t   fin_reg, fin_next;
    logic [7:0]  prescale_reg, prescale_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            issue_reg    <= '0;
            ev_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            prescale_reg <= 8'd0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            ev_valid_reg <= ev_valid_next;
            cnt_reg      <= cnt_next;
            prescale_reg <= prescale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ev_idx_reg <= ev_idx_next;
        pend_reg   <= pend_next;
        fin_reg    <= fin_next;
    end

    always_comb
    begin
        logic [8:0]        wide;
        logic              hit;
        logic              push_pend;
        logic              we_c;
        entry_t            wd_c;
        out_item_t         run_c;
        out_item_t         fin_c;
        out_item_t         pend_c;
        logic [NW-1:0]     cnt_c;
        logic [SLOT_W-1:0] slot_c;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        issue_next    = issue_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        fin_next      = fin_reg;
        prescale_next = prescale_reg;

        item_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = issue_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = ev_idx_reg;
        wr_data    = rd_data;
        res_valid  = 1'b0;
        res        = fin_reg;

        wide      = {1'b0, prescale_reg} + 9'd1;
        hit       = 1'b0;
        push_pend = 1'b0;
        we_c      = 1'b0;
        wd_c      = rd_data;
        fin_c     = fin_reg;
        pend_c    = pend_reg;
        cnt_c     = cnt_reg;
        slot_c    = SLOT_W'(ev_idx_reg);
        run_c     = '{kind: KIND_RUN, run_id: rd_data.ident, slot: slot_c,
                      task_status: ST_RUNNING, last: 1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd_next      = item;
                    issue_next    = '0;
                    ev_valid_next = 1'b0;
                    cnt_next      = '0;
                    if (item.action == ACT_TICK)
                    begin
                        if (wide >= {1'b0, tick_divide})
                        begin
                            prescale_next = 8'd0;
                            state_next    = S_SCAN;
                        end
                        else
                        begin
                            prescale_next = wide[7:0];
                            fin_next      = '{kind: KIND_TICK_DONE, run_id: 8'd0,
                                              slot: '0, task_status: ST_RUNNABLE,
                                              last: 1'b1};
                            state_next    = S_FINISH;
                        end
                    end
                    else if (item.action == ACT_ADD || item.action == ACT_DELETE ||
                             item.action == ACT_STATUS || item.action == ACT_DISPATCH)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (ev_valid_reg)
                begin
                    priority if (cmd_reg.action == ACT_ADD)
                    begin
                        if (rd_data.state == ST_STOPPED)
                        begin
                            hit  = 1'b1;
                            we_c = 1'b1;
                            wd_c = '{ident: cmd_reg.task_id, period: cmd_reg.period,
                                     countdown: cmd_reg.period, state: ST_RUNNABLE};
                            fin_c = '{kind: KIND_ADDED, run_id: cmd_reg.task_id,
                                      slot: slot_c, task_status: ST_RUNNABLE,
                                      last: 1'b1};
                        end
                    end
                    else if (cmd_reg.action == ACT_DELETE)
                    begin
                        if (rd_data.ident == cmd_reg.task_id)
                        begin
                            hit        = 1'b1;
                            we_c       = 1'b1;
                            wd_c.state = ST_STOPPED;
                            fin_c = '{kind: KIND_DELETED, run_id: cmd_reg.task_id,
                                      slot: slot_c, task_status: ST_STOPPED,
                                      last: 1'b1};
                        end
                    end
                    else if (cmd_reg.action == ACT_STATUS)
                    begin
                        if (rd_data.ident == cmd_reg.task_id)
                        begin
                            hit   = 1'b1;
                            fin_c = '{kind: KIND_STATUS, run_id: cmd_reg.task_id,
                                      slot: slot_c, task_status: rd_data.state,
                                      last: 1'b1};
                        end
                    end
                    else if (cmd_reg.action == ACT_TICK)
                    begin
                        if (rd_data.state == ST_RUNNABLE && rd_data.countdown != 16'd0)
                        begin
                            we_c           = 1'b1;
                            wd_c.countdown = rd_data.countdown - 16'd1;
                        end
                    end
                    else
                    begin
                        if (rd_data.state == ST_RUNNABLE && rd_data.countdown == 16'd0)
                        begin
                            we_c           = 1'b1;
                            wd_c.countdown = rd_data.period;
                            push_pend      = (cnt_reg != '0);
                            cnt_c          = cnt_reg + NW'(1);
                            if (cnt_reg == NW'(MAX_RESULTS - 1))
                            begin
                                // result cap reached: this run closes the dispatch
                                hit        = 1'b1;
                                fin_c      = run_c;
                                fin_c.last = 1'b1;
                            end
                            else
                            begin
                                pend_c = run_c;
                            end
                        end
                    end
                end

                // previous run goes out only once a newer one proves it is not last
                res_valid = push_pend;
                res       = pend_reg;

                if (!(push_pend && !res_ready))
                begin
                    wr_en     = we_c;
                    wr_data   = wd_c;
                    cnt_next  = cnt_c;
                    pend_next = pend_c;
                    fin_next  = fin_c;
                    if (hit)
                    begin
                        ev_valid_next = 1'b0;
                        state_next    = S_FINISH;
                    end
                    else if (issue_reg != CW'(NUM_SLOTS))
                    begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = issue_reg[AW-1:0];
                        issue_next    = issue_reg + CW'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                        state_next    = S_FINISH;
                        priority if (cmd_reg.action == ACT_ADD)
                        begin
                            fin_next = '{kind: KIND_FULL, run_id: cmd_reg.task_id,
                                         slot: '0, task_status: ST_ERROR, last: 1'b1};
                        end
                        else if (cmd_reg.action == ACT_DELETE)
                        begin
                            fin_next = '{kind: KIND_NOT_FOUND, run_id: cmd_reg.task_id,
                                         slot: '0, task_status: ST_ERROR, last: 1'b1};
                        end
                        else if (cmd_reg.action == ACT_STATUS)
                        begin
                            fin_next = '{kind: KIND_STATUS, run_id: cmd_reg.task_id,
                                         slot: '0, task_status: ST_ERROR, last: 1'b1};
                        end
                        else if (cmd_reg.action == ACT_TICK)
                        begin
                            fin_next = '{kind: KIND_TICK_DONE, run_id: 8'd0,
                                         slot: '0, task_status: ST_RUNNABLE, last: 1'b1};
                        end
                        else if (cnt_c != '0)
                        begin
                            fin_next      = pend_c;
                            fin_next.last = 1'b1;
                        end
                        else
                        begin
                            fin_next = '{kind: KIND_NONE_READY, run_id: 8'd0,
                                         slot: '0, task_status: ST_RUNNABLE, last: 1'b1};
                        end
                    end
                end
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                res       = fin_reg;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/periodic_task_slot_scheduler.sv =====
`default_nettype none
`include "assert_macros.svh"

// Periodic task slot scheduler. Commands (add, delete, status, tick,
// dispatch) arrive one at a time on the item channel; results leave on the
// result channel with last set on the final result of each command. The
// slot table sits in a single-port-read memory walked one entry per cycle
// unless a run result is held back, so a full-table scan (dispatch short
// of MAX_RESULTS runs, a wrapping tick, a miss) finishes after the last
// slot, an add/delete/status that hits slot k finishes there, and a tick
// that does not wrap the prescaler skips the walk; the next command is
// taken once that final result has entered the output register. Unknown
// action codes are dropped in the cycle they are taken and give no result.
// Any command stretches while the output register is full, and dispatch
// also while a run result waits ahead of it, since at most one run result
// is held there. A new command is taken while the previous final result
// still waits in the output register. Reset state is available at once:
// per-slot written flags stand in for a clearing pass. tick_divide may be
// written only while no command is in progress.
module periodic_task_slot_scheduler #(
    parameter int NUM_SLOTS = ptss_pkg::NUM_SLOTS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire ptss_pkg::in_item_t item,
    output logic                result_valid,
    input  wire logic           result_ready,
    output ptss_pkg::out_item_t result,
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_data
);
    import ptss_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [7:0]    tick_divide_reg;
    logic          result_valid_reg;
    out_item_t     result_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          seq_res_valid;
    out_item_t     seq_res;
    logic          res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg <= TICK_DIVIDE_RST;
        end
        else if (cfg_we)
        begin
            tick_divide_reg <= cfg_data;
        end
    end

    // output register: takes a new result when empty or being drained
    assign res_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= seq_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && seq_res_valid)
        begin
            result_reg <= seq_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    ptss_table #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ptss_seq #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .tick_divide (tick_divide_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res_valid   (seq_res_valid),
        .res         (seq_res),
        .res_ready   (res_ready)
    );

    // write-back always trails the read pointer, so no same-entry overlap
    `PTSS_NEVER(a_no_rw_collide, clk, rst_n, rd_en && wr_en && (rd_addr == wr_addr), "read and write hit the same slot")
    // while waiting for a command the table and result path stay quiet
    `PTSS_ASSERT(a_idle_quiet, clk, rst_n, item_ready |-> (!rd_en && !wr_en && !seq_res_valid), "table or result activity while idle")
    // a result held back by a full output register is still offered next cycle
    `PTSS_ASSERT(a_push_holds, clk, rst_n, (seq_res_valid && !res_ready) |=> seq_res_valid, "pending result dropped")

endmodule

`default_nettype wire
